### sv/ilmj_pkg.sv
`timescale 1ns / 1ps

package ilmj_pkg;

  localparam int ID_W = 64;
  localparam int OP_W = 2;
  localparam int ST_W = 2;
  localparam int FI_W = 16;
  localparam int SI_W = 6;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam longint DEF_FIRST_INDEX_LIMIT = 65536;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_PROBE = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [ST_W-1:0] ST_ACK      = 2'd0;
  localparam logic [ST_W-1:0] ST_MATCH    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOMATCH  = 2'd2;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

  // command broadcast along the row of cells
  typedef struct packed {
    logic load;   // write the broadcast id into the selected cell
    logic probe;  // compare every occupied cell against the broadcast id
    logic step;   // retire the granted match flag
  } chain_cmd_t;

endpackage

### sv/ilmj_cell.sv
`timescale 1ns / 1ps

module ilmj_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ilmj_pkg::chain_cmd_t      cmd,
  input  logic [ilmj_pkg::ID_W-1:0] id_in,
  input  logic                      occupied,
  input  logic                      write_sel,
  input  logic                      below_in,
  output logic                      below_out,
  output logic                      grant,
  output logic                      rest
);

  logic [ilmj_pkg::ID_W-1:0] id_q;
  logic                      flag;

  always_ff @(posedge clk) begin
    if (cmd.load && write_sel) begin
      id_q <= id_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (cmd.probe) begin
      flag <= occupied && (id_q == id_in);
    end else if (cmd.step && grant) begin
      flag <= 1'b0;
    end
  end

  // lowest pending match wins, the chain carries "some match below"
  assign grant     = flag && !below_in;
  assign below_out = below_in || flag;
  assign rest      = flag && !grant;

endmodule

### sv/ilmj_chain.sv
`timescale 1ns / 1ps

module ilmj_chain #(
  parameter int TABLE_DEPTH = ilmj_pkg::DEF_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ilmj_pkg::chain_cmd_t                 cmd,
  input  logic [ilmj_pkg::ID_W-1:0]            id_in,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
  output logic                                 any_flag,
  output logic                                 any_rest,
  output logic [ilmj_pkg::SI_W-1:0]            grant_index
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [TABLE_DEPTH:0]   below;
  logic [TABLE_DEPTH-1:0] grant;
  logic [TABLE_DEPTH-1:0] rest;

  assign below[0] = 1'b0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ilmj_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .id_in     (id_in),
      .occupied  (CW'(i) < count),
      .write_sel (count == CW'(i)),
      .below_in  (below[i]),
      .below_out (below[i+1]),
      .grant     (grant[i]),
      .rest      (rest[i])
    );
  end

  assign any_flag = below[TABLE_DEPTH];
  assign any_rest = |rest;

  // grant is one-hot or zero
  always_comb begin
    grant_index = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (grant[i]) begin
        grant_index = grant_index | ilmj_pkg::SI_W'(i);
      end
    end
  end

endmodule

### sv/id_list_match_join.sv
`timescale 1ns / 1ps

// channel | handshake            | payload
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | op, id_value
// out     | out_valid / out_ready| status, first_index, second_index, matched_id, last
//
// an item is taken on in_valid and in_ready; clear and load then give their single word,
// a probe gives one word per matching entry (at least one) at one word per cycle while out_ready
// holds high, set by the row of compare cells that retires its lowest match flag per word sent.
// a new item is taken once the previous item's last word sits in the output register.
// reset clears the entry count, probe counter and match flags; table contents are
// undefined until loaded and need no clearing pass. out_ready low simply holds the chain.

module id_list_match_join #(
  parameter int     TABLE_DEPTH       = ilmj_pkg::DEF_TABLE_DEPTH,
  parameter longint FIRST_INDEX_LIMIT = ilmj_pkg::DEF_FIRST_INDEX_LIMIT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ilmj_pkg::OP_W-1:0]        op,
  input  logic signed [ilmj_pkg::ID_W-1:0] id_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ilmj_pkg::ST_W-1:0]        status,
  output logic [ilmj_pkg::FI_W-1:0]        first_index,
  output logic [ilmj_pkg::SI_W-1:0]        second_index,
  output logic signed [ilmj_pkg::ID_W-1:0] matched_id,
  output logic                             last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(FIRST_INDEX_LIMIT + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [PW-1:0] probe_cnt;

  // pending single word, or match context while scanning
  logic [ilmj_pkg::ST_W-1:0] pend_status;
  logic [ilmj_pkg::FI_W-1:0] pend_fi;
  logic [ilmj_pkg::SI_W-1:0] pend_si;
  logic [ilmj_pkg::ID_W-1:0] pend_id;
  logic                      pend_scan;

  logic                      accept;
  logic                      table_full;
  logic                      probe_over;
  logic                      out_load;
  logic                      emit;
  logic                      emit_match;
  logic                      any_flag;
  logic                      any_rest;
  logic [ilmj_pkg::SI_W-1:0] grant_index;
  ilmj_pkg::chain_cmd_t      cmd;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = (count >= CW'(TABLE_DEPTH));
  assign probe_over = (probe_cnt >= PW'(FIRST_INDEX_LIMIT));
  assign out_load   = !out_valid || out_ready;
  assign emit       = (state == S_EMIT) && out_load;
  assign emit_match = emit && pend_scan && any_flag;

  assign cmd.load  = accept && (op == ilmj_pkg::OP_LOAD) && !table_full;
  assign cmd.probe = accept && (op == ilmj_pkg::OP_PROBE) && !probe_over;
  assign cmd.step  = emit_match;

  ilmj_chain #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_chain (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .id_in       (id_value),
    .count       (count),
    .any_flag    (any_flag),
    .any_rest    (any_rest),
    .grant_index (grant_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      probe_cnt <= '0;
      pend_scan <= 1'b0;
    end else begin
      if (accept) begin
        unique case (op)
          ilmj_pkg::OP_CLEAR: begin
            count       <= '0;
            probe_cnt   <= '0;
            pend_status <= ilmj_pkg::ST_ACK;
            pend_fi     <= '0;
            pend_si     <= '0;
            pend_id     <= '0;
            pend_scan   <= 1'b0;
            state       <= S_EMIT;
          end
          ilmj_pkg::OP_LOAD: begin
            pend_fi   <= '0;
            pend_scan <= 1'b0;
            state     <= S_EMIT;
            if (table_full) begin
              pend_status <= ilmj_pkg::ST_OVERFLOW;
              pend_si     <= '0;
              pend_id     <= '0;
            end else begin
              pend_status <= ilmj_pkg::ST_ACK;
              pend_si     <= ilmj_pkg::SI_W'(count);
              pend_id     <= id_value;
              count       <= count + CW'(1);
            end
          end
          ilmj_pkg::OP_PROBE: begin
            pend_si <= '0;
            state   <= S_EMIT;
            if (probe_over) begin
              pend_status <= ilmj_pkg::ST_OVERFLOW;
              pend_fi     <= '0;
              pend_id     <= '0;
              pend_scan   <= 1'b0;
            end else begin
              pend_status <= ilmj_pkg::ST_NOMATCH;
              pend_fi     <= ilmj_pkg::FI_W'(probe_cnt);
              pend_id     <= id_value;
              pend_scan   <= 1'b1;
              probe_cnt   <= probe_cnt + PW'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (emit && !(emit_match && any_rest)) begin
        state <= S_IDLE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      first_index <= pend_fi;
      matched_id  <= pend_id;
      if (emit_match) begin
        status       <= ilmj_pkg::ST_MATCH;
        second_index <= grant_index;
        last         <= !any_rest;
      end else begin
        status       <= pend_status;
        second_index <= pend_si;
        last         <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    probe_cnt <= PW'(FIRST_INDEX_LIMIT))
    else $error("probe counter beyond limit");

  a_last_match_drains: assert property (@(posedge clk) disable iff (rst)
    emit_match && !any_rest |=> !any_flag && state == S_IDLE)
    else $error("match flags left after last match word");

  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("output word without emit state");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    accept && op != ilmj_pkg::OP_NONE |=> !in_ready)
    else $error("input taken while a word is pending");
`endif

endmodule
